// ===== hdl/imusi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package imusi_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int AtanLen = 24;
   localparam int AtanIdxW = 5;
   localparam int AngleW = 16;
   localparam int AngleShift = 17;
   localparam int AccelW = 32;
   localparam int StateW = 32;
   localparam int DtW = 16;
   localparam int GravW = 31;
   localparam int CsrDataW = 31;
   localparam int WorkW = 36;
   localparam int SumW = WorkW + 1;
   localparam int TrigW = 33;
   localparam int ZW = 35;
   localparam int ChunkW = 18;
   localparam int PartW = ChunkW + 1;
   localparam int ProdW = WorkW + PartW;
   localparam int AccW = 70;
   localparam int RotShift = 30;
   localparam int DtShift = 16;
   localparam int PcW = 5;
   localparam int ProgLen = 18;

   localparam logic [DtW-1:0] TimeStepReset = 16'd6554;
   localparam logic [GravW-1:0] GravityReset = 31'd642908;
   localparam logic signed [TrigW-1:0] CordicGain = 33'sd652032875;
   localparam logic signed [ZW-1:0] Q30Pi = 35'sd3373259426;
   localparam logic signed [ZW-1:0] Q30HalfPi = 35'sd1686629713;

   typedef enum logic [0:0] {
      CSR_TIME_STEP = 1'b0,
      CSR_GRAVITY   = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      ASEL_A0,
      ASEL_A1,
      ASEL_A2,
      ASEL_V0,
      ASEL_V1,
      ASEL_V2
   } asel_type;

   typedef enum logic [2:0] {
      BSEL_COS_ROLL,
      BSEL_COS_PITCH,
      BSEL_COS_YAW,
      BSEL_SIN_ROLL,
      BSEL_SIN_PITCH,
      BSEL_SIN_YAW,
      BSEL_DT
   } bsel_type;

   typedef enum logic [2:0] {
      WB_NONE,
      WB_TMP,
      WB_PAIR,
      WB_VEL,
      WB_POS
   } wb_type;

   typedef struct packed {
      asel_type   a_sel;
      bsel_type   b_sel;
      logic       neg;
      logic       first;
      wb_type     wb;
      logic [1:0] p_idx;
      logic [1:0] q_idx;
      logic       grav;
   } prog_entry_type;

   typedef struct packed {
      logic                load;
      logic                cordic_step;
      logic [AtanIdxW-1:0] iter;
      logic                mul_en;
      logic                hi;
      logic                wb_en;
      logic                publish;
      prog_entry_type      op;
   } dp_cmd_type;

   function automatic logic signed [ZW-1:0] atan_q30(input logic [AtanIdxW-1:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         5'd0: v = 35'sd843314857;
         5'd1: v = 35'sd497837829;
         5'd2: v = 35'sd263043837;
         5'd3: v = 35'sd133525159;
         5'd4: v = 35'sd67021687;
         5'd5: v = 35'sd33543516;
         5'd6: v = 35'sd16775851;
         5'd7: v = 35'sd8388437;
         5'd8: v = 35'sd4194283;
         5'd9: v = 35'sd2097149;
         5'd10: v = 35'sd1048576;
         5'd11: v = 35'sd524288;
         5'd12: v = 35'sd262144;
         5'd13: v = 35'sd131072;
         5'd14: v = 35'sd65536;
         5'd15: v = 35'sd32768;
         5'd16: v = 35'sd16384;
         5'd17: v = 35'sd8192;
         5'd18: v = 35'sd4096;
         5'd19: v = 35'sd2048;
         5'd20: v = 35'sd1024;
         5'd21: v = 35'sd512;
         5'd22: v = 35'sd256;
         5'd23: v = 35'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic prog_entry_type mk(input asel_type a, input bsel_type b,
                                         input logic neg, input logic first,
                                         input wb_type wb, input logic [1:0] p,
                                         input logic [1:0] q, input logic grav);
      prog_entry_type e;
      e.a_sel = a;
      e.b_sel = b;
      e.neg = neg;
      e.first = first;
      e.wb = wb;
      e.p_idx = p;
      e.q_idx = q;
      e.grav = grav;
      return e;
   endfunction

   // Each rotation is p' = c*p - s*q, q' = s*p + c*q; yaw, then roll, then pitch.
   function automatic prog_entry_type prog_entry(input logic [PcW-1:0] pc);
      prog_entry_type e;
      unique case (pc)
         5'd0: e = mk(ASEL_A0, BSEL_COS_YAW, 1'b0, 1'b1, WB_NONE, 2'd0, 2'd1, 1'b0);
         5'd1: e = mk(ASEL_A1, BSEL_SIN_YAW, 1'b1, 1'b0, WB_TMP, 2'd0, 2'd1, 1'b0);
         5'd2: e = mk(ASEL_A0, BSEL_SIN_YAW, 1'b0, 1'b1, WB_NONE, 2'd0, 2'd1, 1'b0);
         5'd3: e = mk(ASEL_A1, BSEL_COS_YAW, 1'b0, 1'b0, WB_PAIR, 2'd0, 2'd1, 1'b0);
         5'd4: e = mk(ASEL_A1, BSEL_COS_ROLL, 1'b0, 1'b1, WB_NONE, 2'd1, 2'd2, 1'b0);
         5'd5: e = mk(ASEL_A2, BSEL_SIN_ROLL, 1'b1, 1'b0, WB_TMP, 2'd1, 2'd2, 1'b0);
         5'd6: e = mk(ASEL_A1, BSEL_SIN_ROLL, 1'b0, 1'b1, WB_NONE, 2'd1, 2'd2, 1'b0);
         5'd7: e = mk(ASEL_A2, BSEL_COS_ROLL, 1'b0, 1'b0, WB_PAIR, 2'd1, 2'd2, 1'b0);
         5'd8: e = mk(ASEL_A2, BSEL_COS_PITCH, 1'b0, 1'b1, WB_NONE, 2'd2, 2'd0, 1'b0);
         5'd9: e = mk(ASEL_A0, BSEL_SIN_PITCH, 1'b1, 1'b0, WB_TMP, 2'd2, 2'd0, 1'b0);
         5'd10: e = mk(ASEL_A2, BSEL_SIN_PITCH, 1'b0, 1'b1, WB_NONE, 2'd2, 2'd0, 1'b0);
         5'd11: e = mk(ASEL_A0, BSEL_COS_PITCH, 1'b0, 1'b0, WB_PAIR, 2'd2, 2'd0, 1'b1);
         5'd12: e = mk(ASEL_A0, BSEL_DT, 1'b0, 1'b1, WB_VEL, 2'd0, 2'd0, 1'b0);
         5'd13: e = mk(ASEL_V0, BSEL_DT, 1'b0, 1'b1, WB_POS, 2'd0, 2'd0, 1'b0);
         5'd14: e = mk(ASEL_A1, BSEL_DT, 1'b0, 1'b1, WB_VEL, 2'd0, 2'd1, 1'b0);
         5'd15: e = mk(ASEL_V1, BSEL_DT, 1'b0, 1'b1, WB_POS, 2'd0, 2'd1, 1'b0);
         5'd16: e = mk(ASEL_A2, BSEL_DT, 1'b0, 1'b1, WB_VEL, 2'd0, 2'd2, 1'b0);
         5'd17: e = mk(ASEL_V2, BSEL_DT, 1'b0, 1'b1, WB_POS, 2'd0, 2'd2, 1'b0);
         default: e = mk(ASEL_A0, BSEL_DT, 1'b0, 1'b1, WB_NONE, 2'd0, 2'd0, 1'b0);
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/imusi_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module imusi_ctrl #(
   parameter int CORDIC_STEPS = imusi_pkg::CordicStepsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output imusi_pkg::dp_cmd_type  cmd
);

   localparam int StepW = $clog2(CORDIC_STEPS);
   localparam int IdxW = imusi_pkg::AtanIdxW;
   localparam int PcW = imusi_pkg::PcW;

   imusi_pkg::state_type state_ff, state_in;
   logic [StepW-1:0] iter_ff, iter_in;
   logic [PcW-1:0]   pc_ff, pc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   imusi_pkg::prog_entry_type op;
   logic             publish;

   assign op = imusi_pkg::prog_entry(pc_ff);
   assign publish = (state_ff == imusi_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      iter_in = iter_ff;
      pc_in = pc_ff;
      unique case (state_ff)
         imusi_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = imusi_pkg::ST_CORDIC;
               iter_in = '0;
            end
         end
         imusi_pkg::ST_CORDIC: begin
            iter_in = iter_ff + 1'b1;
            if (iter_ff == StepW'(CORDIC_STEPS - 1)) begin
               state_in = imusi_pkg::ST_MUL_LO;
               pc_in = '0;
            end
         end
         imusi_pkg::ST_MUL_LO: begin
            state_in = imusi_pkg::ST_MUL_HI;
         end
         imusi_pkg::ST_MUL_HI: begin
            if (op.wb != imusi_pkg::WB_NONE) begin
               state_in = imusi_pkg::ST_WRITE;
            end else begin
               state_in = imusi_pkg::ST_MUL_LO;
               pc_in = pc_ff + 1'b1;
            end
         end
         imusi_pkg::ST_WRITE: begin
            if (pc_ff == PcW'(imusi_pkg::ProgLen - 1)) begin
               state_in = imusi_pkg::ST_DONE;
            end else begin
               state_in = imusi_pkg::ST_MUL_LO;
               pc_in = pc_ff + 1'b1;
            end
         end
         imusi_pkg::ST_DONE: begin
            if (publish) begin
               state_in = imusi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = imusi_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.iter = IdxW'(iter_ff);
      cmd.op = op;
      unique case (state_ff)
         imusi_pkg::ST_IDLE:   cmd.load = req_valid;
         imusi_pkg::ST_CORDIC: cmd.cordic_step = 1'b1;
         imusi_pkg::ST_MUL_LO: cmd.mul_en = 1'b1;
         imusi_pkg::ST_MUL_HI: begin
            cmd.mul_en = 1'b1;
            cmd.hi = 1'b1;
         end
         imusi_pkg::ST_WRITE:  cmd.wb_en = 1'b1;
         imusi_pkg::ST_DONE:   cmd.publish = publish;
         default:              cmd.load = 1'b0;
      endcase
   end

   assign rsp_valid_in = publish | (rsp_valid_ff & rsp_stall);
   assign req_stall = (state_ff != imusi_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imusi_pkg::ST_IDLE;
         iter_ff <= '0;
         pc_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         iter_ff <= iter_in;
         pc_ff <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/imusi_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module imusi_datapath (
   input  logic                                      clock,
   input  logic                                      reset,
   input  imusi_pkg::dp_cmd_type                     cmd,
   input  logic signed [imusi_pkg::AngleW-1:0]       req_roll_angle,
   input  logic signed [imusi_pkg::AngleW-1:0]       req_pitch_angle,
   input  logic signed [imusi_pkg::AngleW-1:0]       req_yaw_angle,
   input  logic signed [imusi_pkg::AccelW-1:0]       req_accel_body_x,
   input  logic signed [imusi_pkg::AccelW-1:0]       req_accel_body_y,
   input  logic signed [imusi_pkg::AccelW-1:0]       req_accel_body_z,
   input  logic                                      csr_write_enable,
   input  logic [0:0]                                csr_index,
   input  logic [imusi_pkg::CsrDataW-1:0]            csr_write_data,
   output logic signed [imusi_pkg::StateW-1:0]       rsp_vel_x,
   output logic signed [imusi_pkg::StateW-1:0]       rsp_vel_y,
   output logic signed [imusi_pkg::StateW-1:0]       rsp_vel_z,
   output logic signed [imusi_pkg::StateW-1:0]       rsp_pos_x,
   output logic signed [imusi_pkg::StateW-1:0]       rsp_pos_y,
   output logic signed [imusi_pkg::StateW-1:0]       rsp_pos_z
);

   localparam int AngleW = imusi_pkg::AngleW;
   localparam int StateW = imusi_pkg::StateW;
   localparam int DtW = imusi_pkg::DtW;
   localparam int GravW = imusi_pkg::GravW;
   localparam int WorkW = imusi_pkg::WorkW;
   localparam int SumW = imusi_pkg::SumW;
   localparam int TrigW = imusi_pkg::TrigW;
   localparam int ZW = imusi_pkg::ZW;
   localparam int ChunkW = imusi_pkg::ChunkW;
   localparam int PartW = imusi_pkg::PartW;
   localparam int ProdW = imusi_pkg::ProdW;
   localparam int AccW = imusi_pkg::AccW;
   localparam int RotShift = imusi_pkg::RotShift;
   localparam int DtShift = imusi_pkg::DtShift;
   localparam int AngPad = ZW - AngleW - imusi_pkg::AngleShift;

   logic [DtW-1:0]   time_step_ff, time_step_in;
   logic [GravW-1:0] gravity_ff, gravity_in;

   logic signed [WorkW-1:0]  a_ff [3];
   logic signed [WorkW-1:0]  a_in [3];
   logic signed [TrigW-1:0]  x_ff [3];
   logic signed [TrigW-1:0]  x_in [3];
   logic signed [TrigW-1:0]  y_ff [3];
   logic signed [TrigW-1:0]  y_in [3];
   logic signed [ZW-1:0]     z_ff [3];
   logic signed [ZW-1:0]     z_in [3];
   logic                     flip_ff [3];
   logic                     flip_in [3];
   logic signed [StateW-1:0] vel_ff [3];
   logic signed [StateW-1:0] vel_in [3];
   logic signed [StateW-1:0] pos_ff [3];
   logic signed [StateW-1:0] pos_in [3];
   logic signed [StateW-1:0] out_vel_ff [3];
   logic signed [StateW-1:0] out_vel_in [3];
   logic signed [StateW-1:0] out_pos_ff [3];
   logic signed [StateW-1:0] out_pos_in [3];
   logic signed [AccW-1:0]   acc_ff, acc_in;
   logic signed [WorkW-1:0]  tmp_ff, tmp_in;

   logic signed [AngleW-1:0] ang_word [3];
   logic signed [ZW-1:0]     ang_wide [3];
   logic signed [TrigW-1:0]  cos_v [3];
   logic signed [TrigW-1:0]  sin_v [3];
   logic signed [WorkW-1:0]  a_op, b_op;
   logic signed [PartW-1:0]  part;
   logic signed [ProdW-1:0]  prod;
   logic signed [AccW-1:0]   term, base;
   logic signed [AccW-1:0]   rot_rnd, dt_rnd;
   logic signed [WorkW-1:0]  rot_val, dt_val;
   logic signed [SumW-1:0]   vel_sum, pos_sum;
   logic signed [WorkW-1:0]  grav_ext;

   function automatic logic signed [StateW-1:0] sat_state(input logic signed [SumW-1:0] v);
      logic [SumW-StateW:0] top;
      logic signed [StateW-1:0] r;
      top = v[SumW-1:StateW-1];
      if ((&top) || !(|top)) begin
         r = v[StateW-1:0];
      end else if (v[SumW-1]) begin
         r = {1'b1, {(StateW-1){1'b0}}};
      end else begin
         r = {1'b0, {(StateW-1){1'b1}}};
      end
      return r;
   endfunction

   assign ang_word[0] = req_roll_angle;
   assign ang_word[1] = req_pitch_angle;
   assign ang_word[2] = req_yaw_angle;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         ang_wide[l] = $signed({{AngPad{ang_word[l][AngleW-1]}}, ang_word[l],
                                {imusi_pkg::AngleShift{1'b0}}});
         cos_v[l] = flip_ff[l] ? -x_ff[l] : x_ff[l];
         sin_v[l] = flip_ff[l] ? -y_ff[l] : y_ff[l];
      end
   end

   always_comb begin
      case (cmd.op.a_sel)
         imusi_pkg::ASEL_A0: a_op = a_ff[0];
         imusi_pkg::ASEL_A1: a_op = a_ff[1];
         imusi_pkg::ASEL_A2: a_op = a_ff[2];
         imusi_pkg::ASEL_V0: a_op = WorkW'(vel_ff[0]);
         imusi_pkg::ASEL_V1: a_op = WorkW'(vel_ff[1]);
         imusi_pkg::ASEL_V2: a_op = WorkW'(vel_ff[2]);
         default:            a_op = '0;
      endcase
      case (cmd.op.b_sel)
         imusi_pkg::BSEL_COS_ROLL:  b_op = WorkW'(cos_v[0]);
         imusi_pkg::BSEL_COS_PITCH: b_op = WorkW'(cos_v[1]);
         imusi_pkg::BSEL_COS_YAW:   b_op = WorkW'(cos_v[2]);
         imusi_pkg::BSEL_SIN_ROLL:  b_op = WorkW'(sin_v[0]);
         imusi_pkg::BSEL_SIN_PITCH: b_op = WorkW'(sin_v[1]);
         imusi_pkg::BSEL_SIN_YAW:   b_op = WorkW'(sin_v[2]);
         imusi_pkg::BSEL_DT:        b_op = $signed({{(WorkW-DtW){1'b0}}, time_step_ff});
         default:                   b_op = '0;
      endcase
   end

   // Two passes per product: the low 18 bits as an unsigned digit, then the signed high digit.
   assign part = cmd.hi ? $signed({b_op[WorkW-1], b_op[WorkW-1:ChunkW]})
                        : $signed({1'b0, b_op[ChunkW-1:0]});
   assign prod = a_op * part;
   assign term = cmd.hi ? (AccW'(prod) <<< ChunkW) : AccW'(prod);
   assign base = (cmd.op.first && !cmd.hi) ? '0 : acc_ff;

   assign rot_rnd = acc_ff + (AccW'(1) <<< (RotShift - 1));
   assign dt_rnd = acc_ff + (AccW'(1) <<< (DtShift - 1));
   assign rot_val = rot_rnd[RotShift +: WorkW];
   assign dt_val = dt_rnd[DtShift +: WorkW];
   assign grav_ext = $signed({{(WorkW-GravW){1'b0}}, gravity_ff});
   assign vel_sum = SumW'(vel_ff[cmd.op.q_idx]) + SumW'(dt_val);
   assign pos_sum = SumW'(pos_ff[cmd.op.q_idx]) + SumW'(dt_val);

   always_comb begin
      time_step_in = time_step_ff;
      gravity_in = gravity_ff;
      if (csr_write_enable) begin
         unique case (imusi_pkg::csr_index_type'(csr_index))
            imusi_pkg::CSR_TIME_STEP: time_step_in = csr_write_data[DtW-1:0];
            imusi_pkg::CSR_GRAVITY:   gravity_in = csr_write_data[GravW-1:0];
            default:                  time_step_in = time_step_ff;
         endcase
      end
   end

   always_comb begin
      acc_in = acc_ff;
      tmp_in = tmp_ff;
      for (int l = 0; l < 3; l++) begin
         a_in[l] = a_ff[l];
         x_in[l] = x_ff[l];
         y_in[l] = y_ff[l];
         z_in[l] = z_ff[l];
         flip_in[l] = flip_ff[l];
         vel_in[l] = vel_ff[l];
         pos_in[l] = pos_ff[l];
         out_vel_in[l] = out_vel_ff[l];
         out_pos_in[l] = out_pos_ff[l];
      end

      if (cmd.load) begin
         a_in[0] = WorkW'(req_accel_body_x);
         a_in[1] = WorkW'(req_accel_body_y);
         a_in[2] = WorkW'(req_accel_body_z);
         for (int l = 0; l < 3; l++) begin
            x_in[l] = imusi_pkg::CordicGain;
            y_in[l] = '0;
            if (ang_wide[l] > imusi_pkg::Q30HalfPi) begin
               z_in[l] = ang_wide[l] - imusi_pkg::Q30Pi;
               flip_in[l] = 1'b1;
            end else if (ang_wide[l] < -imusi_pkg::Q30HalfPi) begin
               z_in[l] = ang_wide[l] + imusi_pkg::Q30Pi;
               flip_in[l] = 1'b1;
            end else begin
               z_in[l] = ang_wide[l];
               flip_in[l] = 1'b0;
            end
         end
      end

      if (cmd.cordic_step) begin
         for (int l = 0; l < 3; l++) begin
            if (!z_ff[l][ZW-1]) begin
               x_in[l] = x_ff[l] - (y_ff[l] >>> cmd.iter);
               y_in[l] = y_ff[l] + (x_ff[l] >>> cmd.iter);
               z_in[l] = z_ff[l] - imusi_pkg::atan_q30(cmd.iter);
            end else begin
               x_in[l] = x_ff[l] + (y_ff[l] >>> cmd.iter);
               y_in[l] = y_ff[l] - (x_ff[l] >>> cmd.iter);
               z_in[l] = z_ff[l] + imusi_pkg::atan_q30(cmd.iter);
            end
         end
      end

      if (cmd.mul_en) begin
         acc_in = cmd.op.neg ? (base - term) : (base + term);
      end

      if (cmd.wb_en) begin
         case (cmd.op.wb)
            imusi_pkg::WB_TMP: tmp_in = rot_val;
            imusi_pkg::WB_PAIR: begin
               a_in[cmd.op.p_idx] = cmd.op.grav ? (tmp_ff - grav_ext) : tmp_ff;
               a_in[cmd.op.q_idx] = rot_val;
            end
            imusi_pkg::WB_VEL: vel_in[cmd.op.q_idx] = sat_state(vel_sum);
            imusi_pkg::WB_POS: pos_in[cmd.op.q_idx] = sat_state(pos_sum);
            default: tmp_in = tmp_ff;
         endcase
      end

      if (cmd.publish) begin
         for (int l = 0; l < 3; l++) begin
            out_vel_in[l] = vel_ff[l];
            out_pos_in[l] = pos_ff[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= imusi_pkg::TimeStepReset;
         gravity_ff <= imusi_pkg::GravityReset;
         for (int l = 0; l < 3; l++) begin
            vel_ff[l] <= '0;
            pos_ff[l] <= '0;
         end
      end else begin
         time_step_ff <= time_step_in;
         gravity_ff <= gravity_in;
         for (int l = 0; l < 3; l++) begin
            vel_ff[l] <= vel_in[l];
            pos_ff[l] <= pos_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      tmp_ff <= tmp_in;
      for (int l = 0; l < 3; l++) begin
         a_ff[l] <= a_in[l];
         x_ff[l] <= x_in[l];
         y_ff[l] <= y_in[l];
         z_ff[l] <= z_in[l];
         flip_ff[l] <= flip_in[l];
         out_vel_ff[l] <= out_vel_in[l];
         out_pos_ff[l] <= out_pos_in[l];
      end
   end

   assign rsp_vel_x = out_vel_ff[0];
   assign rsp_vel_y = out_vel_ff[1];
   assign rsp_vel_z = out_vel_ff[2];
   assign rsp_pos_x = out_pos_ff[0];
   assign rsp_pos_y = out_pos_ff[1];
   assign rsp_pos_z = out_pos_ff[2];

endmodule

`default_nettype wire

// ===== hdl/imu_strapdown_integrator.sv =====
// Strapdown integrator: each accepted transfer carries roll, pitch and yaw (Q2.13 rad) and a
// body-frame acceleration (Q16.16). The acceleration is rotated into the global frame (yaw
// about Z, roll about X, pitch about Y), gravity is removed from Z, and the stored velocity
// and position are advanced by time_step with saturation; each result transfer returns the
// new velocity and position. The three sine/cosine pairs come from three CORDIC lanes running
// side by side, then eighteen products go one after another through a single 36 x 19
// multiplier, two passes per product, with a write-back step after each completed sum. One
// item is worked on at a time; a finished result sits in an output register while the next
// item is taken.
`timescale 1ns / 1ps
`default_nettype none

module imu_strapdown_integrator #(
   parameter int CORDIC_STEPS = imusi_pkg::CordicStepsDefault
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [imusi_pkg::AngleW-1:0]    req_roll_angle,
   input  logic signed [imusi_pkg::AngleW-1:0]    req_pitch_angle,
   input  logic signed [imusi_pkg::AngleW-1:0]    req_yaw_angle,
   input  logic signed [imusi_pkg::AccelW-1:0]    req_accel_body_x,
   input  logic signed [imusi_pkg::AccelW-1:0]    req_accel_body_y,
   input  logic signed [imusi_pkg::AccelW-1:0]    req_accel_body_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [imusi_pkg::StateW-1:0]    rsp_vel_x,
   output logic signed [imusi_pkg::StateW-1:0]    rsp_vel_y,
   output logic signed [imusi_pkg::StateW-1:0]    rsp_vel_z,
   output logic signed [imusi_pkg::StateW-1:0]    rsp_pos_x,
   output logic signed [imusi_pkg::StateW-1:0]    rsp_pos_y,
   output logic signed [imusi_pkg::StateW-1:0]    rsp_pos_z,
   input  logic                                   csr_write_enable,
   input  logic [0:0]                             csr_index,
   input  logic [imusi_pkg::CsrDataW-1:0]         csr_write_data
);

   imusi_pkg::dp_cmd_type cmd;

   imusi_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd(cmd)
   );

   imusi_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .req_roll_angle(req_roll_angle),
      .req_pitch_angle(req_pitch_angle),
      .req_yaw_angle(req_yaw_angle),
      .req_accel_body_x(req_accel_body_x),
      .req_accel_body_y(req_accel_body_y),
      .req_accel_body_z(req_accel_body_z),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .rsp_vel_x(rsp_vel_x),
      .rsp_vel_y(rsp_vel_y),
      .rsp_vel_z(rsp_vel_z),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_pos_z(rsp_pos_z)
   );

endmodule

`default_nettype wire

// ===== hdl/imusi_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module imusi_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not held off after a transfer");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an item in progress");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset did not clear the handshake");

endmodule

bind imu_strapdown_integrator imusi_checker u_imusi_checker (.*);

`default_nettype wire
